// File: sv/mexp_pkg.sv
// shared constants, state encoding and chain control for the modular exponentiation core
package mexp_pkg;

   localparam int WIDTH = 32;
   localparam int CNT_W = $clog2(WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MUL,
      ST_SQR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } chain_ctrl_type;

endpackage

// File: sv/mexp_cell.sv
// one bit cell of the operand shift chain
module mexp_cell (
   input  logic clock,
   input  logic load,
   input  logic shift,
   input  logic load_bit,
   input  logic shift_in,
   output logic bit_out
);

   logic bit_ff;
   logic bit_in;

   always_comb begin
      bit_in = bit_ff;
      if (load) begin
         bit_in = load_bit;
      end else if (shift) begin
         bit_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign bit_out = bit_ff;

endmodule

// File: sv/mexp_shift_chain.sv
// row of bit cells that hands the operand towards the top one bit a cycle while shift is high
module mexp_shift_chain (
   input  logic                          clock,
   input  mexp_pkg::chain_ctrl_type      ctrl,
   input  logic [mexp_pkg::WIDTH-1:0]    load_data,
   output logic                          msb
);

   logic [mexp_pkg::WIDTH-1:0] cell_q;

   for (genvar i = 0; i < mexp_pkg::WIDTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         mexp_cell u_cell (
            .clock    (clock),
            .load     (ctrl.load),
            .shift    (ctrl.shift),
            .load_bit (load_data[i]),
            .shift_in (1'b0),
            .bit_out  (cell_q[i])
         );
      end else begin : g_rest
         mexp_cell u_cell (
            .clock    (clock),
            .load     (ctrl.load),
            .shift    (ctrl.shift),
            .load_bit (load_data[i]),
            .shift_in (cell_q[i-1]),
            .bit_out  (cell_q[i])
         );
      end
   end

   assign msb = cell_q[mexp_pkg::WIDTH-1];

endmodule

// File: sv/modular_exponentiation_core.sv
// modular exponentiation core: right-to-left square and multiply over a bit-cell chain
//
// Computes base ^ exponent mod modulus for one word at a time. A word is taken when
// start is high while busy is low; the result appears on rsp_result for exactly one
// cycle with rsp_valid high and must be captured then, as the receiver cannot stall.
// One item first reduces the base, then for each exponent bit up to the highest set one
// runs a check step and a squaring, with a multiply before the squaring when the bit is
// set, and finally presents the result. The single shared modular multiplier serves both
// the multiply and the squaring and consumes one multiplier bit per cycle from the shift
// chain. A modulus of zero wraps all arithmetic modulo 2^32; a zero exponent returns 1.
// The modulus is written through the csr channel, accepted only while the core is idle.
module modular_exponentiation_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [mexp_pkg::WIDTH-1:0] req_base,
   input  logic [mexp_pkg::WIDTH-1:0] req_exponent,
   output logic                       rsp_valid,
   output logic [mexp_pkg::WIDTH-1:0] rsp_result,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [mexp_pkg::WIDTH-1:0] csr_data
);

   localparam int W = mexp_pkg::WIDTH;

   mexp_pkg::state_type      state_ff, state_in;
   logic [mexp_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]             mod_ff, mod_in;
   logic [W-1:0]             base_ff, base_in;   // reduced running base
   logic [W-1:0]             exp_ff, exp_in;     // remaining exponent bits
   logic [W-1:0]             res_ff, res_in;     // running result
   logic [W-1:0]             prod_ff, prod_in;   // multiplier accumulator

   mexp_pkg::chain_ctrl_type chain_ctrl;
   logic [W-1:0]             chain_data;
   logic                     chain_msb;
   logic                     last_step;
   logic                     wrap;

   // arithmetic of one step
   logic [W:0] dbl_raw, dbl_red, sum_raw, sum_red, red_raw, red_red;
   logic [W-1:0] mul_step, red_step;

   mexp_shift_chain u_chain (
      .clock     (clock),
      .ctrl      (chain_ctrl),
      .load_data (chain_data),
      .msb       (chain_msb)
   );

   assign last_step = (cnt_ff == mexp_pkg::CNT_W'(W - 1));
   assign wrap      = (mod_ff == '0);

   // one cycle of shift-and-add: double, reduce, add the base if the bit is set, reduce
   always_comb begin
      dbl_raw = {prod_ff, 1'b0};
      dbl_red = dbl_raw;
      if (wrap) begin
         dbl_red = {1'b0, dbl_raw[W-1:0]};
      end else if (dbl_raw >= {1'b0, mod_ff}) begin
         dbl_red = dbl_raw - {1'b0, mod_ff};
      end
      sum_raw = {1'b0, dbl_red[W-1:0]} + (chain_msb ? {1'b0, base_ff} : '0);
      sum_red = sum_raw;
      if (wrap) begin
         sum_red = {1'b0, sum_raw[W-1:0]};
      end else if (sum_raw >= {1'b0, mod_ff}) begin
         sum_red = sum_raw - {1'b0, mod_ff};
      end
      mul_step = sum_red[W-1:0];

      // restoring remainder step for the initial base reduction
      red_raw = {prod_ff, chain_msb};
      red_red = red_raw;
      if (!wrap && red_raw >= {1'b0, mod_ff}) begin
         red_red = red_raw - {1'b0, mod_ff};
      end
      red_step = red_red[W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (start) begin
               state_in = mexp_pkg::ST_REDUCE;
            end
         end
         mexp_pkg::ST_REDUCE: begin
            if (last_step) begin
               state_in = mexp_pkg::ST_CHECK;
            end
         end
         mexp_pkg::ST_CHECK: begin
            if (exp_ff == '0) begin
               state_in = mexp_pkg::ST_DONE;
            end else if (exp_ff[0]) begin
               state_in = mexp_pkg::ST_MUL;
            end else begin
               state_in = mexp_pkg::ST_SQR;
            end
         end
         mexp_pkg::ST_MUL: begin
            if (last_step) begin
               state_in = mexp_pkg::ST_SQR;
            end
         end
         mexp_pkg::ST_SQR: begin
            if (last_step) begin
               state_in = mexp_pkg::ST_CHECK;
            end
         end
         mexp_pkg::ST_DONE: state_in = mexp_pkg::ST_IDLE;
         default:           state_in = mexp_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      cnt_in           = cnt_ff;
      mod_in           = mod_ff;
      base_in          = base_ff;
      exp_in           = exp_ff;
      res_in           = res_ff;
      prod_in          = prod_ff;
      chain_ctrl.load  = 1'b0;
      chain_ctrl.shift = 1'b0;
      chain_data       = base_ff;
      busy             = 1'b1;
      rsp_valid        = 1'b0;
      csr_ready        = 1'b0;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            busy      = 1'b0;
            csr_ready = 1'b1;
            if (csr_valid) begin
               mod_in = csr_data;
            end
            if (start) begin
               // chain takes the raw base for the reduction pass
               chain_ctrl.load = 1'b1;
               chain_data      = req_base;
               exp_in          = req_exponent;
               res_in          = W'(1);
               prod_in         = '0;
               cnt_in          = '0;
            end
         end
         mexp_pkg::ST_REDUCE: begin
            chain_ctrl.shift = 1'b1;
            prod_in          = red_step;
            cnt_in           = cnt_ff + 1'b1;
            if (last_step) begin
               base_in = red_step;
            end
         end
         mexp_pkg::ST_CHECK: begin
            // multiply by the result on a set bit, otherwise go straight to squaring
            chain_ctrl.load = (exp_ff != '0);
            chain_data      = exp_ff[0] ? res_ff : base_ff;
            prod_in         = '0;
            cnt_in          = '0;
         end
         mexp_pkg::ST_MUL: begin
            chain_ctrl.shift = 1'b1;
            prod_in          = mul_step;
            cnt_in           = cnt_ff + 1'b1;
            if (last_step) begin
               res_in           = mul_step;
               chain_ctrl.load  = 1'b1;
               chain_data       = base_ff;
               prod_in          = '0;
            end
         end
         mexp_pkg::ST_SQR: begin
            chain_ctrl.shift = 1'b1;
            prod_in          = mul_step;
            cnt_in           = cnt_ff + 1'b1;
            if (last_step) begin
               base_in = mul_step;
               exp_in  = {1'b0, exp_ff[W-1:1]};
            end
         end
         mexp_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mexp_pkg::ST_IDLE;
         mod_ff   <= W'(1);
      end else begin
         state_ff <= state_in;
         mod_ff   <= mod_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      base_ff <= base_in;
      exp_ff  <= exp_in;
      res_ff  <= res_in;
      prod_ff <= prod_in;
   end

   assign rsp_result = res_ff;

   // a result strobe is always followed by an idle core
   a_done_then_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("core still busy after result word");

   // an accepted word always starts the base reduction
   a_start_reduces : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == mexp_pkg::ST_REDUCE && cnt_ff == '0))
      else $error("accepted word did not start reduction");

   // the modulus never moves while an item is in flight
   a_mod_stable : assert property (@(posedge clock) disable iff (reset)
      (busy && $past(busy)) |-> $stable(mod_ff))
      else $error("modulus changed during an item");

endmodule
